/* rtl/cpl_pkg.sv */
// Shared constants and helpers for the column projection line finder.
// Used by the top level; no dependencies.
package cpl_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int CNT_W      = 11;
  localparam int PIX_W      = 8;
  localparam int POS_W      = 10;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

/* rtl/cpl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/column_projection_line_finder.sv */
// Top level of the column projection line finder: raster pixel input, per-frame result.
// Depends on cpl_pkg and cpl_ram.
//
// Accepts one pixel per clock while in_stall is low. Each pixel does a read-modify-write
// of its column count in a single-port-per-direction RAM: the read is issued when the
// pixel is accepted, the updated count is written in the next cycle, and a bypass covers
// a column that is hit by pixels accepted back to back (image width of one). The result
// of a frame is registered in the s1 stage and then waits in a two-entry result buffer,
// so frames of a single pixel also stream at one pixel per clock while out_stall is low.
// The input stalls only on the last pixel of a frame while both buffer entries would
// still hold unclaimed results. The count memory needs no clearing after reset: the
// first row of every frame writes fresh counts.
module column_projection_line_finder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cpl_pkg::PIX_W-1:0]        in_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_found,
  output logic [cpl_pkg::POS_W-1:0]        out_column,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cpl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpl_pkg::SIZE_W-1:0]       cfg_data
);

  localparam int AW  = cpl_pkg::ADDR_W;
  localparam int RW  = cpl_pkg::ROW_W;
  localparam int SW  = cpl_pkg::SIZE_W;
  localparam int CW  = cpl_pkg::CNT_W;
  localparam int PW  = cpl_pkg::POS_W;
  localparam int LW  = CW + 4;

  logic [SW-1:0] width_r, height_r;
  logic [SW-1:0] w_eff, h_eff;

  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic          s1_valid_r;
  logic [AW-1:0] s1_x_r;
  logic          s1_set_r, s1_first_r, s1_last_r, s1_end_r;

  logic          fwd_hit_r;
  logic [CW-1:0] fwd_data_r;

  logic          in_run_r, in_run_nxt;
  logic [AW-1:0] run_start_r, run_start_nxt;
  logic          decided_r, decided_nxt;
  logic [PW-1:0] found_pos_r, found_pos_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r;
  logic [PW-1:0] out_pos_r;
  logic          spare_valid_r, spare_valid_nxt;
  logic          spare_found_r;
  logic [PW-1:0] spare_pos_r;
  logic          res_push, res_pop;
  logic [1:0]    res_level;

  logic          row_end, last_row, frame_end, in_acc;
  logic [CW-1:0] rdata, prev_cnt, cnt;
  logic [CW:0]   sum;
  logic          line;
  logic [AW:0]   mid_sum;
  logic          res_found;
  logic [PW-1:0] res_pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cpl_pkg::WIDTH_RESET;
      height_r <= cpl_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpl_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        cpl_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = cpl_pkg::clamp_size(width_r,  SW'(cpl_pkg::MAX_WIDTH));
  assign h_eff = cpl_pkg::clamp_size(height_r, SW'(cpl_pkg::MAX_HEIGHT));

  assign row_end   = (SW'(col_r) + SW'(1)) >= w_eff;
  assign last_row  = (SW'(row_r) + SW'(1)) >= h_eff;
  assign frame_end = row_end && last_row;

  assign res_push  = s1_valid_r && s1_end_r;
  assign res_pop   = out_valid_r && !out_stall;
  assign res_level = 2'(out_valid_r) + 2'(spare_valid_r) + 2'(res_push) - 2'(res_pop);

  assign in_stall = frame_end && (res_level >= 2'd2);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (!row_end) begin
        col_nxt = col_r + AW'(1);
      end else begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= in_acc;
      fwd_hit_r  <= in_acc && s1_valid_r && (s1_x_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r     <= col_r;
      s1_set_r   <= (in_pixel != '0);
      s1_first_r <= (row_r == '0);
      s1_last_r  <= last_row;
      s1_end_r   <= frame_end;
    end
    fwd_data_r <= cnt;
  end

  cpl_ram #(
    .WIDTH (CW),
    .DEPTH (cpl_pkg::MAX_WIDTH)
  ) u_counts (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_x_r),
    .wdata (cnt),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (rdata)
  );

  always_comb begin
    prev_cnt = fwd_hit_r ? fwd_data_r : rdata;
    sum      = {1'b0, prev_cnt} + (CW+1)'(s1_set_r);
    if (s1_first_r) begin
      cnt = CW'(s1_set_r);
    end else if (sum > (CW+1)'(cpl_pkg::COUNT_MAX)) begin
      cnt = cpl_pkg::COUNT_MAX;
    end else begin
      cnt = sum[CW-1:0];
    end
    line    = (LW'(cnt) * LW'(10)) > (LW'(h_eff) * LW'(3));
    mid_sum = {1'b0, run_start_r} + {1'b0, s1_x_r};

    in_run_nxt    = in_run_r;
    run_start_nxt = run_start_r;
    decided_nxt   = decided_r;
    found_pos_nxt = found_pos_r;
    if (s1_valid_r && s1_last_r && !decided_r) begin
      if (line) begin
        if (!in_run_r) begin
          in_run_nxt    = 1'b1;
          run_start_nxt = s1_x_r;
        end
      end else if (in_run_r) begin
        decided_nxt   = 1'b1;
        found_pos_nxt = PW'(mid_sum[AW:1]);
      end
    end

    res_found = decided_nxt || in_run_nxt;
    if (decided_nxt) begin
      res_pos = found_pos_nxt;
    end else if (in_run_nxt) begin
      res_pos = PW'(run_start_nxt);
    end else begin
      res_pos = '0;
    end

    if (res_push) begin
      in_run_nxt    = 1'b0;
      run_start_nxt = '0;
      decided_nxt   = 1'b0;
      found_pos_nxt = '0;
    end

    out_valid_nxt   = out_valid_r && !res_pop;
    spare_valid_nxt = spare_valid_r || res_push;
    if (!out_valid_nxt) begin
      out_valid_nxt   = spare_valid_r || res_push;
      spare_valid_nxt = spare_valid_r && res_push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r      <= 1'b0;
      run_start_r   <= '0;
      decided_r     <= 1'b0;
      found_pos_r   <= '0;
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      in_run_r      <= in_run_nxt;
      run_start_r   <= run_start_nxt;
      decided_r     <= decided_nxt;
      found_pos_r   <= found_pos_nxt;
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || res_pop) begin
      if (spare_valid_r) begin
        out_found_r <= spare_found_r;
        out_pos_r   <= spare_pos_r;
      end else if (res_push) begin
        out_found_r <= res_found;
        out_pos_r   <= res_pos;
      end
    end
    if (res_push && (spare_valid_r || (out_valid_r && !res_pop))) begin
      spare_found_r <= res_found;
      spare_pos_r   <= res_pos;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_column = out_pos_r;

`ifndef SYNTHESIS
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && spare_valid_r) |-> res_pop)
    else $error("frame result arrived while both result entries were held");

  a_spare_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    spare_valid_r |-> out_valid_r)
    else $error("spare result held without a head result");

  a_frame_end_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_end) |=> (s1_valid_r && s1_end_r) ##1 out_valid)
    else $error("last pixel of frame did not produce a result");

  a_not_found_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_column == '0))
    else $error("position nonzero without a found line");
`endif

endmodule
